// File: rtl/kop_pkg.sv
// shared types, constants and arithmetic helpers of the kepler orbit position block
package kop_pkg;

  localparam int unsigned MaxIter   = 16;
  localparam int unsigned IterW     = $clog2(MaxIter);
  localparam int unsigned TolW      = 21;
  localparam int unsigned TolReset  = 1193;
  localparam int unsigned CordSteps = 30;
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned CntW      = 6;

  typedef logic signed [39:0] kop_word_t;

  localparam kop_word_t One30    = 40'sd1073741824;
  localparam kop_word_t Gain30   = 40'sd652032874;
  localparam kop_word_t InvTwoPi = 40'sd683565276;

  typedef struct packed {
    logic [31:0] eccentricity;
    logic [31:0] perihelion_distance;
    logic [31:0] inclination;
    logic [31:0] arg_perihelion;
    logic [31:0] node_longitude;
    logic [31:0] mean_anomaly;
  } kop_in_t;

  typedef struct packed {
    logic signed [31:0] ecl_longitude;
    logic signed [31:0] ecl_latitude;
    logic [31:0]        radial_distance;
    logic               not_converged;
    logic               distance_saturated;
  } kop_res_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_30,
    SH_32
  } kop_sh_e;

  typedef enum logic [5:0] {
    S_IDLE, S_CORD, S_DIV, S_SQRT,
    S_G1, S_G2, S_G3, S_G4, S_G5,
    S_N1, S_N2, S_N3, S_N4, S_N5,
    S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8,
    S_A9, S_A10, S_A11, S_A12, S_A13, S_A14, S_A15, S_A16,
    S_A17, S_A18, S_A19, S_A20, S_A21, S_A22, S_A23
  } kop_state_e;

  // cordic arctangent table in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // sign-magnitude product, truncated toward zero after the shift
  function automatic logic signed [65:0] mulsh(input logic signed [34:0] a,
                                               input logic signed [34:0] b,
                                               input kop_sh_e sh);
    logic        neg;
    logic [33:0] ma;
    logic [33:0] mb;
    logic [67:0] pr;
    logic [67:0] ps;
    neg = a[34] ^ b[34];
    ma  = a[34] ? 34'(-a) : a[33:0];
    mb  = b[34] ? 34'(-b) : b[33:0];
    pr  = 68'(ma) * 68'(mb);
    case (sh)
      SH_30:   ps = pr >> 30;
      SH_32:   ps = pr >> 32;
      default: ps = pr;
    endcase
    return neg ? -$signed({1'b0, ps[64:0]}) : $signed({1'b0, ps[64:0]});
  endfunction

endpackage

// File: rtl/kepler_orbit_position.sv
// kepler orbit position block: orbital elements in, ecliptic position out
//
// One beat of orbital elements is taken when start is high and busy is low; the
// block then works alone on it and raises done_o for exactly one cycle with the
// result on res_o. The receiver cannot stall, so res_o must be taken in that
// cycle. All work runs on one shared 34x34 sign-magnitude multiplier, one shared
// cordic stage (30 steps, rotation or vectoring), a bit-serial restoring divider
// (64 steps) and a bit-serial square root (32 steps), all under one sequencer.
// The work runs in order: the starting guess is one cordic rotation plus
// multiplies; then come 1 to 16 newton steps, each one cordic rotation,
// multiplies, one 64-step division and one update; the tail is the axis
// division, the square root, four rotations and three vectoring passes. With
// zero eccentricity the square root is skipped. The tolerance register is
// written over its own valid/ready channel, always ready, and is meant to be
// written only while the block is idle.
module kepler_orbit_position (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  kop_pkg::kop_in_t          item_i,
  output logic                      done_o,
  output kop_pkg::kop_res_t         res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kop_pkg::TolW-1:0]  cfg_data_i
);

  // control state
  kop_pkg::kop_state_e state_q, state_d, ret_q, ret_d;
  logic [kop_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [kop_pkg::IterW-1:0] k_q, k_d;
  logic [kop_pkg::TolW-1:0]  tol_q;
  logic done_q, done_d, conv_q, conv_d, sat_q, sat_d;
  logic czero_q, czero_d, cflip_q, cflip_d, cvec_q, cvec_d, fneg_q, fneg_d;

  // latched elements and working registers
  logic [31:0] e_q, e_d, q_q, q_d, inc_q, inc_d, w_q, w_d, node_q, node_d, m_q, m_d;
  logic [31:0] ea_q, ea_d, a_q, a_d, u_q, u_d, rad_q, rad_d, lon_q, lon_d;
  logic [32:0] s_q, s_d;
  kop_pkg::kop_word_t cx_q, cx_d, cy_q, cy_d;
  logic signed [33:0] cz_q, cz_d;
  logic signed [65:0] p_q, p_d;
  kop_pkg::kop_word_t g_q, g_d, xv_q, xv_d, yv_q, yv_d, acc_q, acc_d;
  kop_pkg::kop_word_t pu_q, pu_d, xh_q, xh_d, yh_q, yh_d, zh_q, zh_d;
  logic signed [31:0] sn_q, sn_d, cn_q, cn_d, su_q, su_d, cu_q, cu_d;
  logic [63:0] dnum_q, dnum_d, sq_r_q, sq_r_d, sq_bit_q, sq_bit_d;
  logic [33:0] drem_q, drem_d;
  logic [32:0] dden_q, dden_d;
  kop_pkg::kop_res_t res_q, res_d;

  // shared multiplier operands
  logic signed [34:0] mul_a, mul_b;
  kop_pkg::kop_sh_e   mul_sh;
  logic signed [65:0] mprod;

  // unit launch requests
  logic        rot_go, vec_go, div_go;
  logic [31:0] rot_ang;
  kop_pkg::kop_word_t vec_y, vec_x;
  logic [63:0] div_num;
  logic [32:0] div_den;
  kop_pkg::kop_state_e go_ret;

  // cordic stage
  logic [4:0]         cidx;
  logic signed [33:0] cat;
  kop_pkg::kop_word_t cdx, cdy, rx, ry;
  logic               cpos;
  logic signed [31:0] rot_s, rot_c;
  logic [31:0]        vec_ang;
  logic [31:0]        rot_a0;
  logic               rot_flip;

  // divider and square root steps
  logic [33:0] dsh, drem_n;
  logic        dge;
  logic [63:0] strial;
  logic        sge;

  // newton helpers
  logic signed [31:0] adif;
  logic signed [33:0] fval;
  logic [32:0]        nabs;
  logic [31:0]        e1, dl, dlabs;

  // vector sums
  kop_pkg::kop_word_t sum_ap, h_val;
  logic signed [31:0] lat_s;

  assign busy        = (state_q != kop_pkg::S_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  assign mprod = kop_pkg::mulsh(mul_a, mul_b, mul_sh);

  // one cordic step, shared by rotation and vectoring
  always_comb begin
    cidx = cnt_q[4:0];
    cat  = $signed({2'b00, kop_pkg::atan_turn(cidx)});
    cdx  = cy_q >>> cidx;
    cdy  = cx_q >>> cidx;
    cpos = cvec_q ? (cy_q <= 0) : (cz_q >= 0);
  end

  // rotation result: undo the half-turn fold, clamp to unit range
  always_comb begin
    rx = cflip_q ? -cx_q : cx_q;
    ry = cflip_q ? -cy_q : cy_q;
    if (rx > kop_pkg::One30) rx = kop_pkg::One30;
    if (rx < -kop_pkg::One30) rx = -kop_pkg::One30;
    if (ry > kop_pkg::One30) ry = kop_pkg::One30;
    if (ry < -kop_pkg::One30) ry = -kop_pkg::One30;
    rot_c   = 32'(rx);
    rot_s   = 32'(ry);
    vec_ang = czero_q ? 32'h0 : cz_q[31:0];
    // fold the rotation start angle into the right half plane
    rot_flip = 1'(((rot_ang + 32'h40000000) >> 31));
    rot_a0   = rot_flip ? (rot_ang ^ 32'h80000000) : rot_ang;
  end

  // restoring divider and digit-by-digit square root steps
  always_comb begin
    dsh    = {drem_q[32:0], dnum_q[63]};
    dge    = (dsh >= {1'b0, dden_q});
    drem_n = dge ? (dsh - {1'b0, dden_q}) : dsh;
    strial = sq_r_q + sq_bit_q;
    sge    = (dnum_q >= strial);
  end

  // newton residual and update
  always_comb begin
    adif  = $signed(ea_q - m_q);
    fval  = 34'(adif) - 34'(p_q);
    nabs  = fval[33] ? 33'(-fval) : 33'(fval);
    e1    = fneg_q ? (ea_q + dnum_q[31:0]) : (ea_q - dnum_q[31:0]);
    dl    = e1 - ea_q;
    dlabs = dl[31] ? (~dl + 32'd1) : dl;
    sum_ap = acc_q + kop_pkg::kop_word_t'(p_q);
    h_val  = sum_ap;
    lat_s  = $signed(vec_ang);
  end

  // sequencer: next state, unit launches and datapath updates
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  cnt_d = cnt_q;  k_d = k_q;
    done_d = 1'b0;  conv_d = conv_q;  sat_d = sat_q;
    czero_d = czero_q;  cflip_d = cflip_q;  cvec_d = cvec_q;  fneg_d = fneg_q;
    e_d = e_q;  q_d = q_q;  inc_d = inc_q;  w_d = w_q;  node_d = node_q;  m_d = m_q;
    ea_d = ea_q;  a_d = a_q;  u_d = u_q;  rad_d = rad_q;  lon_d = lon_q;  s_d = s_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;
    g_d = g_q;  xv_d = xv_q;  yv_d = yv_q;  acc_d = acc_q;
    pu_d = pu_q;  xh_d = xh_q;  yh_d = yh_q;  zh_d = zh_q;
    sn_d = sn_q;  cn_d = cn_q;  su_d = su_q;  cu_d = cu_q;
    dnum_d = dnum_q;  drem_d = drem_q;  dden_d = dden_q;
    sq_r_d = sq_r_q;  sq_bit_d = sq_bit_q;
    res_d = res_q;
    p_d = mprod;
    mul_a = '0;  mul_b = '0;  mul_sh = kop_pkg::SH_0;
    rot_go = 1'b0;  vec_go = 1'b0;  div_go = 1'b0;
    rot_ang = ea_q;  vec_y = '0;  vec_x = '0;
    div_num = '0;  div_den = '0;
    go_ret = kop_pkg::S_IDLE;

    unique case (state_q)
      kop_pkg::S_IDLE: begin
        if (start) begin
          e_d = item_i.eccentricity;  q_d = item_i.perihelion_distance;
          inc_d = item_i.inclination;  w_d = item_i.arg_perihelion;
          node_d = item_i.node_longitude;  m_d = item_i.mean_anomaly;
          conv_d = 1'b0;  sat_d = 1'b0;
          rot_go = 1'b1;  rot_ang = item_i.mean_anomaly;  go_ret = kop_pkg::S_G1;
        end
      end
      kop_pkg::S_CORD: begin
        if (cpos) begin
          cx_d = cx_q - cdx;  cy_d = cy_q + cdy;  cz_d = cz_q - cat;
        end else begin
          cx_d = cx_q + cdx;  cy_d = cy_q - cdy;  cz_d = cz_q + cat;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == kop_pkg::CntW'(kop_pkg::CordSteps - 1)) state_d = ret_q;
      end
      kop_pkg::S_DIV: begin
        drem_d = drem_n;
        dnum_d = {dnum_q[62:0], dge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == kop_pkg::CntW'(kop_pkg::DivSteps - 1)) state_d = ret_q;
      end
      kop_pkg::S_SQRT: begin
        if (sge) begin
          dnum_d = dnum_q - strial;
          sq_r_d = (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_d = sq_r_q >> 1;
        end
        sq_bit_d = sq_bit_q >> 2;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == kop_pkg::CntW'(kop_pkg::SqrtSteps - 1)) state_d = ret_q;
      end
      // starting guess
      kop_pkg::S_G1: begin
        mul_a = 35'(rot_c);  mul_b = $signed({3'b000, e_q});  mul_sh = kop_pkg::SH_32;
        state_d = kop_pkg::S_G2;
      end
      kop_pkg::S_G2: begin
        g_d   = kop_pkg::One30 + kop_pkg::kop_word_t'(p_q);
        mul_a = 35'(rot_s);  mul_b = $signed({3'b000, e_q});  mul_sh = kop_pkg::SH_32;
        state_d = kop_pkg::S_G3;
      end
      kop_pkg::S_G3: begin
        mul_a = 35'(p_q);  mul_b = 35'(g_q);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_G4;
      end
      kop_pkg::S_G4: begin
        mul_a = 35'(p_q);  mul_b = 35'(kop_pkg::InvTwoPi);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_G5;
      end
      kop_pkg::S_G5: begin
        ea_d = m_q + p_q[31:0];
        k_d  = '0;
        rot_go = 1'b1;  rot_ang = m_q + p_q[31:0];  go_ret = kop_pkg::S_N1;
      end
      // newton step
      kop_pkg::S_N1: begin
        mul_a = 35'(rot_c);  mul_b = $signed({3'b000, e_q});  mul_sh = kop_pkg::SH_32;
        state_d = kop_pkg::S_N2;
      end
      kop_pkg::S_N2: begin
        g_d   = kop_pkg::One30 - kop_pkg::kop_word_t'(p_q);
        mul_a = 35'(rot_s);  mul_b = $signed({3'b000, e_q});  mul_sh = kop_pkg::SH_32;
        state_d = kop_pkg::S_N3;
      end
      kop_pkg::S_N3: begin
        mul_a = 35'(p_q);  mul_b = 35'(kop_pkg::InvTwoPi);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_N4;
      end
      kop_pkg::S_N4: begin
        fneg_d  = fval[33];
        div_go  = 1'b1;
        div_num = {1'b0, nabs, 30'b0};
        div_den = 33'(g_q);
        go_ret  = kop_pkg::S_N5;
      end
      kop_pkg::S_N5: begin
        ea_d = e1;
        k_d  = k_q + 1'b1;
        if (dlabs <= {11'b0, tol_q}) begin
          conv_d = 1'b1;
        end
        if ((dlabs <= {11'b0, tol_q}) ||
            (k_q == kop_pkg::IterW'(kop_pkg::MaxIter - 1))) begin
          // semi-major axis q / (1 - e)
          div_go  = 1'b1;
          div_num = {q_q, 32'b0};
          div_den = 33'h1_0000_0000 - {1'b0, e_q};
          go_ret  = kop_pkg::S_A1;
        end else begin
          rot_go = 1'b1;  rot_ang = e1;  go_ret = kop_pkg::S_N1;
        end
      end
      // axis, minor-axis scale and orbit-plane position
      kop_pkg::S_A1: begin
        if (|dnum_q[63:32]) begin
          a_d = 32'hFFFFFFFF;  sat_d = 1'b1;
        end else begin
          a_d = dnum_q[31:0];
        end
        mul_a = $signed({3'b000, e_q});  mul_b = $signed({3'b000, e_q});
        mul_sh = kop_pkg::SH_0;
        state_d = kop_pkg::S_A2;
      end
      kop_pkg::S_A2: begin
        if (e_q == 32'h0) begin
          state_d = kop_pkg::S_A3;
        end else begin
          dnum_d   = 64'h0 - p_q[63:0];
          sq_r_d   = '0;
          sq_bit_d = 64'h4000_0000_0000_0000;
          cnt_d    = '0;
          ret_d    = kop_pkg::S_A3;
          state_d  = kop_pkg::S_SQRT;
        end
      end
      kop_pkg::S_A3: begin
        s_d = (e_q == 32'h0) ? 33'h1_0000_0000 : sq_r_q[32:0];
        rot_go = 1'b1;  rot_ang = ea_q;  go_ret = kop_pkg::S_A4;
      end
      kop_pkg::S_A4: begin
        mul_a = 35'(rot_c) - $signed({5'b00000, e_q[31:2]});
        mul_b = $signed({3'b000, a_q});  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A5;
      end
      kop_pkg::S_A5: begin
        xv_d  = kop_pkg::kop_word_t'(p_q);
        mul_a = $signed({3'b000, a_q});  mul_b = $signed({2'b00, s_q});
        mul_sh = kop_pkg::SH_32;
        state_d = kop_pkg::S_A6;
      end
      kop_pkg::S_A6: begin
        mul_a = 35'(rot_s);  mul_b = 35'(p_q);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A7;
      end
      kop_pkg::S_A7: begin
        yv_d   = kop_pkg::kop_word_t'(p_q);
        vec_go = 1'b1;  vec_y = kop_pkg::kop_word_t'(p_q);  vec_x = xv_q;
        go_ret = kop_pkg::S_A8;
      end
      // radius = vector length times cordic gain
      kop_pkg::S_A8: begin
        mul_a = $signed({25'b0, cx_q[39:30]});  mul_b = 35'(kop_pkg::Gain30);
        mul_sh = kop_pkg::SH_0;
        state_d = kop_pkg::S_A9;
      end
      kop_pkg::S_A9: begin
        acc_d = kop_pkg::kop_word_t'(p_q);
        mul_a = $signed({5'b0, cx_q[29:0]});  mul_b = 35'(kop_pkg::Gain30);
        mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A10;
      end
      kop_pkg::S_A10: begin
        if (sum_ap > $signed({8'b0, 32'hFFFFFFFF})) begin
          rad_d = 32'hFFFFFFFF;  sat_d = 1'b1;
        end else begin
          rad_d = sum_ap[31:0];
        end
        u_d = vec_ang + w_q;
        rot_go = 1'b1;  rot_ang = node_q;  go_ret = kop_pkg::S_A11;
      end
      // rotate into the ecliptic frame
      kop_pkg::S_A11: begin
        sn_d = rot_s;  cn_d = rot_c;
        rot_go = 1'b1;  rot_ang = u_q;  go_ret = kop_pkg::S_A12;
      end
      kop_pkg::S_A12: begin
        su_d = rot_s;  cu_d = rot_c;
        rot_go = 1'b1;  rot_ang = inc_q;  go_ret = kop_pkg::S_A13;
      end
      kop_pkg::S_A13: begin
        mul_a = 35'(su_q);  mul_b = 35'(rot_c);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A14;
      end
      kop_pkg::S_A14: begin
        pu_d  = kop_pkg::kop_word_t'(p_q);
        mul_a = 35'(cn_q);  mul_b = 35'(cu_q);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A15;
      end
      kop_pkg::S_A15: begin
        acc_d = kop_pkg::kop_word_t'(p_q);
        mul_a = 35'(sn_q);  mul_b = 35'(pu_q);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A16;
      end
      kop_pkg::S_A16: begin
        xh_d  = acc_q - kop_pkg::kop_word_t'(p_q);
        mul_a = 35'(sn_q);  mul_b = 35'(cu_q);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A17;
      end
      kop_pkg::S_A17: begin
        acc_d = kop_pkg::kop_word_t'(p_q);
        mul_a = 35'(cn_q);  mul_b = 35'(pu_q);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A18;
      end
      kop_pkg::S_A18: begin
        yh_d  = sum_ap;
        mul_a = 35'(su_q);  mul_b = 35'(rot_s);  mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A19;
      end
      kop_pkg::S_A19: begin
        zh_d   = kop_pkg::kop_word_t'(p_q);
        vec_go = 1'b1;  vec_y = yh_q;  vec_x = xh_q;
        go_ret = kop_pkg::S_A20;
      end
      // longitude, then horizontal length for the latitude pass
      kop_pkg::S_A20: begin
        lon_d = vec_ang;
        mul_a = $signed({25'b0, cx_q[39:30]});  mul_b = 35'(kop_pkg::Gain30);
        mul_sh = kop_pkg::SH_0;
        state_d = kop_pkg::S_A21;
      end
      kop_pkg::S_A21: begin
        acc_d = kop_pkg::kop_word_t'(p_q);
        mul_a = $signed({5'b0, cx_q[29:0]});  mul_b = 35'(kop_pkg::Gain30);
        mul_sh = kop_pkg::SH_30;
        state_d = kop_pkg::S_A22;
      end
      kop_pkg::S_A22: begin
        vec_go = 1'b1;  vec_y = zh_q;  vec_x = h_val;
        go_ret = kop_pkg::S_A23;
      end
      kop_pkg::S_A23: begin
        // zero orbit vector gives zero angles
        if ((xv_q == 0) && (yv_q == 0)) begin
          res_d.ecl_longitude = '0;
          res_d.ecl_latitude  = '0;
        end else begin
          res_d.ecl_longitude = $signed(lon_q);
          if (lat_s > 32'sd1073741824) begin
            res_d.ecl_latitude = 32'sd1073741824;
          end else if (lat_s < -32'sd1073741824) begin
            res_d.ecl_latitude = -32'sd1073741824;
          end else begin
            res_d.ecl_latitude = lat_s;
          end
        end
        res_d.radial_distance    = rad_q;
        res_d.not_converged      = ~conv_q;
        res_d.distance_saturated = sat_q;
        done_d  = 1'b1;
        state_d = kop_pkg::S_IDLE;
      end
      default: state_d = kop_pkg::S_IDLE;
    endcase

    // launch of the shared units
    if (rot_go) begin
      cx_d    = kop_pkg::Gain30;
      cy_d    = '0;
      cz_d    = $signed({{2{rot_a0[31]}}, rot_a0});
      cflip_d = rot_flip;
      cvec_d  = 1'b0;
      cnt_d   = '0;
      ret_d   = go_ret;
      state_d = kop_pkg::S_CORD;
    end
    if (vec_go) begin
      czero_d = (vec_x == 0) && (vec_y == 0);
      cflip_d = 1'b0;
      cvec_d  = 1'b1;
      if (vec_x < 0) begin
        cx_d = -vec_x;  cy_d = -vec_y;  cz_d = 34'sd2147483648;
      end else begin
        cx_d = vec_x;   cy_d = vec_y;   cz_d = '0;
      end
      cnt_d   = '0;
      ret_d   = go_ret;
      state_d = kop_pkg::S_CORD;
    end
    if (div_go) begin
      dnum_d  = div_num;
      dden_d  = div_den;
      drem_d  = '0;
      cnt_d   = '0;
      ret_d   = go_ret;
      state_d = kop_pkg::S_DIV;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kop_pkg::S_IDLE;
      ret_q   <= kop_pkg::S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      tol_q   <= kop_pkg::TolW'(kop_pkg::TolReset);
      done_q  <= 1'b0;
      conv_q  <= 1'b0;
      sat_q   <= 1'b0;
      czero_q <= 1'b0;
      cflip_q <= 1'b0;
      cvec_q  <= 1'b0;
      fneg_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      done_q  <= done_d;
      conv_q  <= conv_d;
      sat_q   <= sat_d;
      czero_q <= czero_d;
      cflip_q <= cflip_d;
      cvec_q  <= cvec_d;
      fneg_q  <= fneg_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    e_q <= e_d;  q_q <= q_d;  inc_q <= inc_d;  w_q <= w_d;  node_q <= node_d;  m_q <= m_d;
    ea_q <= ea_d;  a_q <= a_d;  u_q <= u_d;  rad_q <= rad_d;  lon_q <= lon_d;  s_q <= s_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;  p_q <= p_d;
    g_q <= g_d;  xv_q <= xv_d;  yv_q <= yv_d;  acc_q <= acc_d;
    pu_q <= pu_d;  xh_q <= xh_d;  yh_q <= yh_d;  zh_q <= zh_d;
    sn_q <= sn_d;  cn_q <= cn_d;  su_q <= su_d;  cu_q <= cu_d;
    dnum_q <= dnum_d;  drem_q <= drem_d;  dden_q <= dden_d;
    sq_r_q <= sq_r_d;  sq_bit_q <= sq_bit_d;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  // a result beat only comes out once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  // an accepted beat always starts the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat did not start work");

  // latitude clamp holds on every result
  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((res_o.ecl_latitude <= 32'sd1073741824) &&
                (res_o.ecl_latitude >= -32'sd1073741824)))
    else $error("latitude outside quarter turn");
`endif

endmodule
